// File: sv/bas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg
// Types and constants shared by the box-average image shrink block.
// ----------------------------------------------------------------------------
package bas_pkg;

   localparam int POS_BITS   = 13;   // input column / row position
   localparam int OIDX_BITS  = 14;   // output index, also holds hi quotients
   localparam int FAC_BITS   = 16;   // 8.8 factor
   localparam int SPAN_BITS  = 9;    // window span, 1..256
   localparam int AREA_BITS  = 18;   // span product
   localparam int SUM_BITS   = 32;   // column accumulator
   localparam int START_BITS = 22;   // floor(o*f)
   localparam int MAX_HEIGHT = 4096;
   localparam int ONE_FIX    = 256;
   localparam int APB_ADDR_BITS = 5;
   localparam int APB_DATA_BITS = 32;
   localparam int DIV_NUM_BITS  = 32;
   localparam int DIV_DEN_BITS  = 18;
   localparam int DIV_CNT_BITS  = 6;

   typedef enum logic [2:0] {
      REG_IN_WIDTH   = 3'd0,
      REG_IN_HEIGHT  = 3'd1,
      REG_BAND_COUNT = 3'd2,
      REG_X_FACTOR   = 3'd3,
      REG_Y_FACTOR   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [12:0] in_width;
      logic [12:0] in_height;
      logic [2:0]  band_count;
      logic [15:0] x_factor;
      logic [15:0] y_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_OW,
      ST_DIV_OH,
      ST_DIV_HX,
      ST_DIV_HY,
      ST_MUL,
      ST_RD,
      ST_WR,
      ST_DIV_AVG,
      ST_EMIT,
      ST_NEXT
   } state_type;

endpackage

// File: sv/bas_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_req_if / bas_rsp_if
// Valid/ready channels for input samples and averaged results.
// ----------------------------------------------------------------------------
interface bas_req_if #(parameter int SAMPLE_BITS = 8);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   frame_start;
   modport source (output valid, sample, frame_start, input ready);
   modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface bas_rsp_if #(parameter int SAMPLE_BITS = 8);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] average;
   logic [11:0]            out_col;
   logic [11:0]            out_row;
   logic [1:0]             out_band;
   logic                   frame_end;
   modport source (output valid, average, out_col, out_row, out_band, frame_end,
                   input ready);
   modport sink   (input valid, average, out_col, out_row, out_band, frame_end,
                   output ready);
endinterface

// File: sv/bas_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_csr
// APB register file: image size, band count and shrink factors.
// ----------------------------------------------------------------------------
module bas_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bas_pkg::APB_ADDR_BITS-1:0]   paddr,
   input  logic [bas_pkg::APB_DATA_BITS-1:0]   pwdata,
   output logic [bas_pkg::APB_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output bas_pkg::cfg_type                    cfg,
   output logic                                cfg_wr
);
   bas_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr;

   assign pready = 1'b1;
   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign cfg    = cfg_ff;
   assign cfg_wr = wr;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            bas_pkg::REG_IN_WIDTH:   cfg_in.in_width   = pwdata[12:0];
            bas_pkg::REG_IN_HEIGHT:  cfg_in.in_height  = pwdata[12:0];
            bas_pkg::REG_BAND_COUNT: cfg_in.band_count = pwdata[2:0];
            bas_pkg::REG_X_FACTOR:   cfg_in.x_factor   = pwdata[15:0];
            bas_pkg::REG_Y_FACTOR:   cfg_in.y_factor   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         bas_pkg::REG_IN_WIDTH:   prdata = {19'd0, cfg_ff.in_width};
         bas_pkg::REG_IN_HEIGHT:  prdata = {19'd0, cfg_ff.in_height};
         bas_pkg::REG_BAND_COUNT: prdata = {29'd0, cfg_ff.band_count};
         bas_pkg::REG_X_FACTOR:   prdata = {16'd0, cfg_ff.x_factor};
         bas_pkg::REG_Y_FACTOR:   prdata = {16'd0, cfg_ff.y_factor};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width   <= 13'd640;
         cfg_ff.in_height  <= 13'd480;
         cfg_ff.band_count <= 3'd1;
         cfg_ff.x_factor   <= 16'd512;
         cfg_ff.y_factor   <= 16'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: sv/bas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bas_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bas_pkg::DIV_NUM_BITS-1:0]   num,
   input  logic [bas_pkg::DIV_DEN_BITS-1:0]   den,
   output logic                               done,
   output logic [bas_pkg::DIV_NUM_BITS-1:0]   quot
);
   localparam int NB = bas_pkg::DIV_NUM_BITS;
   localparam int DB = bas_pkg::DIV_DEN_BITS;
   localparam int CB = bas_pkg::DIV_CNT_BITS;

   logic [NB-1:0] num_ff, num_in;
   logic [DB-1:0] rem_ff, rem_in, den_ff, shifted;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic          qbit;

   assign shifted = {rem_ff[DB-2:0], num_ff[NB-1]};
   assign qbit    = (shifted >= den_ff);
   assign done    = done_ff;
   assign quot    = num_ff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         cnt_in  = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? (shifted - den_ff) : shifted;
         num_in = {num_ff[NB-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) den_ff <= den;
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

// File: sv/bas_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_mem
// Column accumulator store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bas_mem #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);
   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
endmodule

// File: sv/box_average_image_shrink_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_image_shrink_core
// Box-average downscaler over a band-interleaved raster stream.
// ----------------------------------------------------------------------------
// One sample at a time, paced by the shared divider: each sample takes two
// index divisions, four start products and up to four read-modify-write
// passes, plus a division when a result is averaged and two more after a
// configuration write (output size). Results leave through a register.
// Reset clears the accumulator store, 2*MAX_WIDTH*2^band_bits entries
// (32768 by default), during which no sample is taken.
module box_average_image_shrink_core #(
   parameter int MAX_WIDTH   = 4096,
   parameter int MAX_BANDS   = 4,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   bas_req_if.sink                             req,
   bas_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bas_pkg::APB_ADDR_BITS-1:0]   paddr,
   input  logic [bas_pkg::APB_DATA_BITS-1:0]   pwdata,
   output logic [bas_pkg::APB_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int BAND_BITS = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int ADDR_BITS = 1 + COL_BITS + BAND_BITS;
   localparam int PB = bas_pkg::POS_BITS;
   localparam int OB = bas_pkg::OIDX_BITS;
   localparam int FB = bas_pkg::FAC_BITS;
   localparam int SB = bas_pkg::START_BITS;
   localparam int MB = bas_pkg::SPAN_BITS;
   localparam int AB = bas_pkg::AREA_BITS;
   localparam int UB = bas_pkg::SUM_BITS;
   localparam int NB = bas_pkg::DIV_NUM_BITS;
   localparam int DB = bas_pkg::DIV_DEN_BITS;

   bas_pkg::cfg_type cfg;
   logic             cfg_wr;

   bas_csr u_csr (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .cfg(cfg), .cfg_wr(cfg_wr)
   );

   // effective configuration
   logic [PB-1:0] w_c, h_c;
   logic [3:0]    nb_c;
   logic [FB-1:0] xf_c, yf_c;
   logic [MB-1:0] mw_c, mh_c;
   logic [AB-1:0] area_c;

   always_comb begin
      if (cfg.in_width == '0) w_c = PB'(1);
      else if ({2'b0, cfg.in_width} > 15'(MAX_WIDTH)) w_c = PB'(MAX_WIDTH);
      else w_c = cfg.in_width;
      if (cfg.in_height == '0) h_c = PB'(1);
      else if (cfg.in_height > PB'(bas_pkg::MAX_HEIGHT)) h_c = PB'(bas_pkg::MAX_HEIGHT);
      else h_c = cfg.in_height;
      if (cfg.band_count == '0) nb_c = 4'd1;
      else if ({1'b0, cfg.band_count} > 4'(MAX_BANDS)) nb_c = 4'(MAX_BANDS);
      else nb_c = {1'b0, cfg.band_count};
      xf_c = (cfg.x_factor < FB'(bas_pkg::ONE_FIX)) ? FB'(bas_pkg::ONE_FIX) : cfg.x_factor;
      yf_c = (cfg.y_factor < FB'(bas_pkg::ONE_FIX)) ? FB'(bas_pkg::ONE_FIX) : cfg.y_factor;
      mw_c = MB'(({1'b0, xf_c} + 17'd255) >> 8);
      mh_c = MB'(({1'b0, yf_c} + 17'd255) >> 8);
      area_c = AB'(mw_c * mh_c);
   end

   bas_pkg::state_type state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic                   dirty_ff, dirty_in, issued_ff, issued_in;
   logic [1:0]             k_ff, k_in;
   logic [PB-1:0]          col_ff, col_in, row_ff, row_in;
   logic [BAND_BITS-1:0]   band_ff, band_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [OB-1:0]          ow_ff, ow_in, oh_ff, oh_in, hx_ff, hx_in, hy_ff, hy_in;
   logic [SB-1:0]          s_ff [4];
   logic [SB-1:0]          s_in;
   logic [UB-1:0]          acc_ff, acc_in;
   logic [OB-1:0]          ecol_ff, ecol_in, erow_ff, erow_in;

   logic                   rv_ff, rv_in;
   logic [SAMPLE_BITS-1:0] ravg_ff, ravg_in;
   logic [11:0]            rcol_ff, rcol_in, rrow_ff, rrow_in;
   logic [1:0]             rband_ff, rband_in;
   logic                   rfe_ff, rfe_in;

   // divider
   logic          div_start, div_done;
   logic [NB-1:0] div_num, div_quot;
   logic [DB-1:0] div_den;

   bas_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_quot)
   );

   // accumulator store
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr, mem_addr;
   logic [UB-1:0]        mem_wdata, mem_rdata;

   bas_mem #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(UB)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_addr), .rdata(mem_rdata)
   );

   // current candidate (k[0] picks column, k[1] picks row)
   logic [OB-1:0] cox, coy, mo;
   logic [FB-1:0] mf;
   logic [SB-1:0] sx, sy;
   logic [SB:0]   ex, ey;
   logic          vx, vy, fx, fy, lx, ly, cand;
   logic [UB-1:0] new_sum;
   logic          fe;
   logic [PB-1:0] c_eff, r_eff;
   logic [BAND_BITS-1:0] b_eff;

   assign cox = k_ff[0] ? hx_ff : hx_ff - 1'b1;
   assign coy = k_ff[1] ? hy_ff : hy_ff - 1'b1;
   assign sx  = s_ff[{1'b0, k_ff[0]}];
   assign sy  = s_ff[{1'b1, k_ff[1]}];
   assign ex  = {1'b0, sx} + (SB+1)'(mw_c) - 1'b1;
   assign ey  = {1'b0, sy} + (SB+1)'(mh_c) - 1'b1;
   assign vx  = (k_ff[0] || hx_ff != '0) && (cox < ow_ff) &&
                ((SB+1)'(col_ff) >= {1'b0, sx}) && ((SB+1)'(col_ff) <= ex);
   assign vy  = (k_ff[1] || hy_ff != '0) && (coy < oh_ff) &&
                ((SB+1)'(row_ff) >= {1'b0, sy}) && ((SB+1)'(row_ff) <= ey);
   assign fx  = ((SB+1)'(col_ff) == {1'b0, sx});
   assign fy  = ((SB+1)'(row_ff) == {1'b0, sy});
   assign lx  = ((SB+1)'(col_ff) == ex);
   assign ly  = ((SB+1)'(row_ff) == ey);
   assign cand = vx & vy;
   assign mem_addr = {coy[0], cox[COL_BITS-1:0], band_ff};
   assign new_sum  = (fx && fy) ? UB'(smp_ff) : mem_rdata + UB'(smp_ff);
   assign fe = (ecol_ff == ow_ff - 1'b1) && (erow_ff == oh_ff - 1'b1) &&
               (4'(band_ff) == nb_c - 4'd1);

   // start product for step k: x0, x1, y0, y1
   always_comb begin
      case (k_ff)
         2'd0:    mo = hx_ff - 1'b1;
         2'd1:    mo = hx_ff;
         2'd2:    mo = hy_ff - 1'b1;
         default: mo = hy_ff;
      endcase
      mf   = k_ff[1] ? yf_c : xf_c;
      s_in = SB'((mo * mf) >> 8);
   end

   // position after frame start and range fix
   always_comb begin
      c_eff = req.frame_start ? '0 : col_ff;
      r_eff = req.frame_start ? '0 : row_ff;
      b_eff = req.frame_start ? '0 : band_ff;
      if (4'(b_eff) >= nb_c) b_eff = '0;
      if (c_eff >= w_c) c_eff = '0;
      if (r_eff >= h_c) r_eff = '0;
   end

   assign req.ready = (state_ff == bas_pkg::ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      dirty_in  = dirty_ff | cfg_wr;
      issued_in = issued_ff;
      k_in      = k_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      band_in   = band_ff;
      smp_in    = smp_ff;
      ow_in     = ow_ff;
      oh_in     = oh_ff;
      hx_in     = hx_ff;
      hy_in     = hy_ff;
      acc_in    = acc_ff;
      ecol_in   = ecol_ff;
      erow_in   = erow_ff;
      rv_in     = rv_ff & ~rsp.ready;
      ravg_in   = ravg_ff;
      rcol_in   = rcol_ff;
      rrow_in   = rrow_ff;
      rband_in  = rband_ff;
      rfe_in    = rfe_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mem_we    = 1'b0;
      mem_waddr = mem_addr;
      mem_wdata = new_sum;

      case (state_ff)
         bas_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[ADDR_BITS-1:0];
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff[ADDR_BITS-1:0] == '1) state_in = bas_pkg::ST_IDLE;
         end
         bas_pkg::ST_IDLE: begin
            if (req.valid) begin
               col_in   = c_eff;
               row_in   = r_eff;
               band_in  = b_eff;
               smp_in   = req.sample;
               state_in = dirty_ff ? bas_pkg::ST_DIV_OW : bas_pkg::ST_DIV_HX;
            end
         end
         bas_pkg::ST_DIV_OW, bas_pkg::ST_DIV_OH, bas_pkg::ST_DIV_HX,
         bas_pkg::ST_DIV_HY, bas_pkg::ST_DIV_AVG: begin
            case (state_ff)
               bas_pkg::ST_DIV_OW: begin
                  div_num = NB'({w_c, 8'h00});
                  div_den = DB'(xf_c);
               end
               bas_pkg::ST_DIV_OH: begin
                  div_num = NB'({h_c, 8'h00});
                  div_den = DB'(yf_c);
               end
               bas_pkg::ST_DIV_HX: begin
                  div_num = NB'({col_ff, 8'hFF});
                  div_den = DB'(xf_c);
               end
               bas_pkg::ST_DIV_HY: begin
                  div_num = NB'({row_ff, 8'hFF});
                  div_den = DB'(yf_c);
               end
               default: begin
                  div_num = acc_ff;
                  div_den = DB'(area_c);
               end
            endcase
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               case (state_ff)
                  bas_pkg::ST_DIV_OW: begin
                     ow_in    = OB'(div_quot);
                     state_in = bas_pkg::ST_DIV_OH;
                  end
                  bas_pkg::ST_DIV_OH: begin
                     oh_in    = OB'(div_quot);
                     dirty_in = cfg_wr;
                     state_in = bas_pkg::ST_DIV_HX;
                  end
                  bas_pkg::ST_DIV_HX: begin
                     hx_in    = OB'(div_quot);
                     state_in = bas_pkg::ST_DIV_HY;
                  end
                  bas_pkg::ST_DIV_HY: begin
                     hy_in    = OB'(div_quot);
                     k_in     = 2'd0;
                     state_in = bas_pkg::ST_MUL;
                  end
                  default: begin
                     ravg_in  = SAMPLE_BITS'(div_quot);
                     state_in = bas_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         bas_pkg::ST_MUL: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) state_in = bas_pkg::ST_RD;
         end
         bas_pkg::ST_RD: begin
            if (cand) state_in = bas_pkg::ST_WR;
            else if (k_ff == 2'd3) state_in = bas_pkg::ST_NEXT;
            else k_in = k_ff + 1'b1;
         end
         bas_pkg::ST_WR: begin
            mem_we  = 1'b1;
            acc_in  = new_sum;
            ecol_in = cox;
            erow_in = coy;
            if (lx && ly) state_in = bas_pkg::ST_DIV_AVG;
            else if (k_ff == 2'd3) state_in = bas_pkg::ST_NEXT;
            else begin
               k_in     = k_ff + 1'b1;
               state_in = bas_pkg::ST_RD;
            end
         end
         bas_pkg::ST_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in    = 1'b1;
               rcol_in  = ecol_ff[11:0];
               rrow_in  = erow_ff[11:0];
               rband_in = 2'(band_ff);
               rfe_in   = fe;
               if (k_ff == 2'd3) state_in = bas_pkg::ST_NEXT;
               else begin
                  k_in     = k_ff + 1'b1;
                  state_in = bas_pkg::ST_RD;
               end
            end
         end
         bas_pkg::ST_NEXT: begin
            state_in = bas_pkg::ST_IDLE;
            if (4'(band_ff) + 4'd1 >= nb_c) begin
               band_in = '0;
               if (col_ff + 1'b1 >= w_c) begin
                  col_in = '0;
                  row_in = (row_ff + 1'b1 >= h_c) ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         default: state_in = bas_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == bas_pkg::ST_MUL) s_ff[k_ff] <= s_in;
      smp_ff   <= smp_in;
      acc_ff   <= acc_in;
      ecol_ff  <= ecol_in;
      erow_ff  <= erow_in;
      ravg_ff  <= ravg_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
      rband_ff <= rband_in;
      rfe_ff   <= rfe_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      ow_ff    <= ow_in;
      oh_ff    <= oh_in;
      if (reset) begin
         state_ff  <= bas_pkg::ST_CLEAR;
         clr_ff    <= '0;
         dirty_ff  <= 1'b1;
         issued_ff <= 1'b0;
         k_ff      <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         band_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         dirty_ff  <= dirty_in;
         issued_ff <= issued_in;
         k_ff      <= k_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         band_ff   <= band_in;
         rv_ff     <= rv_in;
      end
   end

   assign rsp.valid     = rv_ff;
   assign rsp.average   = ravg_ff;
   assign rsp.out_col   = rcol_ff;
   assign rsp.out_row   = rrow_ff;
   assign rsp.out_band  = rband_ff;
   assign rsp.frame_end = rfe_ff;
endmodule
